// ===== design/rgd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgd_pkg
// Shared types, constants and channel weight tables for the RGB565 gray
// decimator.
// ----------------------------------------------------------------------------
package rgd_pkg;

  localparam int DEF_DECIMATION = 2;
  localparam int DEF_MAX_DIM    = 4096;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int PIXEL_W   = 16;
  localparam int GRAY_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd720;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd640;

  typedef struct packed {
    logic keep;
    logic row_end;
    logic frame_last;
  } pos_t;

  localparam logic [7:0] RED_WEIGHT [32] = '{
    8'd0,  8'd2,  8'd4,  8'd7,  8'd9,  8'd12, 8'd14, 8'd17,
    8'd19, 8'd22, 8'd24, 8'd27, 8'd29, 8'd31, 8'd34, 8'd36,
    8'd39, 8'd41, 8'd44, 8'd46, 8'd49, 8'd51, 8'd53, 8'd56,
    8'd58, 8'd61, 8'd63, 8'd66, 8'd68, 8'd71, 8'd73, 8'd76
  };

  localparam logic [7:0] GREEN_WEIGHT [64] = '{
    8'd0,   8'd2,   8'd4,   8'd7,   8'd9,   8'd11,  8'd14,  8'd16,
    8'd18,  8'd21,  8'd23,  8'd25,  8'd28,  8'd30,  8'd32,  8'd35,
    8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd53,
    8'd56,  8'd58,  8'd60,  8'd63,  8'd65,  8'd67,  8'd70,  8'd72,
    8'd74,  8'd77,  8'd79,  8'd81,  8'd84,  8'd86,  8'd88,  8'd91,
    8'd93,  8'd95,  8'd98,  8'd100, 8'd102, 8'd105, 8'd107, 8'd109,
    8'd112, 8'd114, 8'd116, 8'd119, 8'd121, 8'd123, 8'd126, 8'd128,
    8'd130, 8'd133, 8'd135, 8'd137, 8'd140, 8'd142, 8'd144, 8'd147
  };

  localparam logic [7:0] BLUE_WEIGHT [32] = '{
    8'd0,  8'd0,  8'd1,  8'd2,  8'd3,  8'd4,  8'd5,  8'd6,
    8'd7,  8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
    8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22,
    8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd29
  };

endpackage

// ===== design/rgd_position.sv =====
// ----------------------------------------------------------------------------
// rgd_position
// Frame size registers and raster column/row counters; flags pixels that
// fall on the decimation grid and the last kept pixel of a row and frame.
// ----------------------------------------------------------------------------
module rgd_position #(
  parameter int DECIMATION = rgd_pkg::DEF_DECIMATION,
  parameter int MAX_DIM    = rgd_pkg::DEF_MAX_DIM
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [rgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgd_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        advance,
  output rgd_pkg::pos_t               pos
);
  import rgd_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam int EW = CW + 2;
  localparam int PW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam logic [EW-1:0]    STEP     = EW'(DECIMATION);
  localparam logic [EW-1:0]    STEP2    = EW'(2 * DECIMATION);
  localparam logic [EW-1:0]    DIM_MAX  = EW'(MAX_DIM);
  localparam logic [CFG_W-1:0] DIM_CLIP = CFG_W'(MAX_DIM);
  localparam logic [PW-1:0]    PH_LAST  = PW'(DECIMATION - 1);

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [CW-1:0]    column_count;
  logic [CW-1:0]    row_count;
  logic [PW-1:0]    col_phase;
  logic [PW-1:0]    row_phase;

  logic [EW-1:0] w_eff;
  logic [EW-1:0] h_eff;
  logic [EW-1:0] col_ext;
  logic [EW-1:0] row_ext;
  logic          keep_col;
  logic          keep_row;
  logic          last_col;
  logic          last_row;
  logic          col_wrap;
  logic          row_wrap;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = EW'(1);
    end else if (frame_width > DIM_CLIP) begin
      w_eff = DIM_MAX;
    end else begin
      w_eff = EW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = EW'(1);
    end else if (frame_height > DIM_CLIP) begin
      h_eff = DIM_MAX;
    end else begin
      h_eff = EW'(frame_height);
    end
  end

  assign col_ext  = EW'(column_count);
  assign row_ext  = EW'(row_count);
  assign keep_col = (col_phase == '0) && (col_ext + STEP <= w_eff);
  assign keep_row = (row_phase == '0) && (row_ext + STEP <= h_eff);
  assign last_col = col_ext + STEP2 > w_eff;
  assign last_row = row_ext + STEP2 > h_eff;
  assign col_wrap = col_ext + EW'(1) >= w_eff;
  assign row_wrap = row_ext + EW'(1) >= h_eff;

  assign pos.keep       = keep_col && keep_row;
  assign pos.row_end    = keep_col && keep_row && last_col;
  assign pos.frame_last = keep_col && keep_row && last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      col_phase    <= '0;
      row_phase    <= '0;
    end else if (advance) begin
      if (col_wrap) begin
        column_count <= '0;
        col_phase    <= '0;
        if (row_wrap) begin
          row_count <= '0;
          row_phase <= '0;
        end else begin
          row_count <= row_count + CW'(1);
          row_phase <= (row_phase == PH_LAST) ? '0 : row_phase + PW'(1);
        end
      end else begin
        column_count <= column_count + CW'(1);
        col_phase    <= (col_phase == PH_LAST) ? '0 : col_phase + PW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_col_phase_zero: assert property (@(posedge clk) disable iff (rst)
    column_count == '0 |-> col_phase == '0)
    else $error("column phase out of step with column counter");

  a_row_phase_zero: assert property (@(posedge clk) disable iff (rst)
    row_count == '0 |-> row_phase == '0)
    else $error("row phase out of step with row counter");

  a_frame_last_kept: assert property (@(posedge clk) disable iff (rst)
    pos.frame_last |-> pos.row_end && pos.keep)
    else $error("frame end flagged on a dropped pixel");
`endif

endmodule

// ===== design/rgd_luma.sv =====
// ----------------------------------------------------------------------------
// rgd_luma
// Splits an RGB565 pixel and sums the table-weighted channels into gray.
// ----------------------------------------------------------------------------
module rgd_luma (
  input  logic [rgd_pkg::PIXEL_W-1:0] pixel,
  output logic [rgd_pkg::GRAY_W-1:0]  gray
);
  import rgd_pkg::*;

  logic [4:0] red;
  logic [5:0] green;
  logic [4:0] blue;
  logic [9:0] sum;

  assign red   = pixel[15:11];
  assign green = pixel[10:5];
  assign blue  = pixel[4:0];
  assign sum   = 10'(RED_WEIGHT[red]) + 10'(GREEN_WEIGHT[green]) + 10'(BLUE_WEIGHT[blue]);
  assign gray  = sum[GRAY_W-1:0];

endmodule

// ===== design/rgb565_gray_decimator_unit.sv =====
// ----------------------------------------------------------------------------
// rgb565_gray_decimator_unit
// RGB565 to gray converter with spatial decimation over a configured frame.
// Pipeline: pixel accept to gray_valid passes an input stage, then a result stage.
// Throughput: one pixel per cycle; a full input stage under gray back-pressure
// holds pixel_ready low.
// Reset: counters cleared, frame size 720 x 640, both stages empty.
// ----------------------------------------------------------------------------
module rgb565_gray_decimator_unit #(
  parameter int DECIMATION = rgd_pkg::DEF_DECIMATION,
  parameter int MAX_DIM    = rgd_pkg::DEF_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [rgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [rgd_pkg::PIXEL_W-1:0]   pixel,
  output logic                          gray_valid,
  input  logic                          gray_ready,
  output logic [rgd_pkg::GRAY_W-1:0]    gray,
  output logic                          row_end,
  output logic                          frame_last
);
  import rgd_pkg::*;

  pos_t               pos;
  logic               accept;
  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;
  logic               s1_row_end;
  logic               s1_frame_last;
  logic               s1_adv;
  logic               out_free;
  logic [GRAY_W-1:0]  gray_next;

  assign out_free    = !gray_valid || gray_ready;
  assign s1_adv      = s1_valid && out_free;
  assign pixel_ready = !s1_valid || out_free;
  assign accept      = pixel_valid && pixel_ready;

  rgd_position #(
    .DECIMATION (DECIMATION),
    .MAX_DIM    (MAX_DIM)
  ) u_position (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .pos       (pos)
  );

  rgd_luma u_luma (
    .pixel (s1_pixel),
    .gray  (gray_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= accept && pos.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel      <= pixel;
      s1_row_end    <= pos.row_end;
      s1_frame_last <= pos.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_valid <= 1'b0;
    end else if (out_free) begin
      gray_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      gray       <= gray_next;
      row_end    <= s1_row_end;
      frame_last <= s1_frame_last;
    end
  end

`ifndef SYNTHESIS
  a_frame_last_row_end: assert property (@(posedge clk) disable iff (rst)
    gray_valid && frame_last |-> row_end)
    else $error("frame end without row end");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && s1_pixel == $past(s1_pixel))
    else $error("input stage lost a stalled pixel");

  a_s1_stall_cause: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> gray_valid && !gray_ready)
    else $error("input stage stalled without output back-pressure");
`endif

endmodule

// ===== test/rgb565_gray_decimator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rgb565_gray_decimator_unit_tb
// Streams RGB565 pixels through the gray decimator across many frame sizes,
// including sizes changed in mid-frame, out-of-range sizes and frames too
// small to keep any pixel. It predicts every gray word and checks it in
// order, with random gaps on the pixel side and random stalls on the gray
// side.
// ----------------------------------------------------------------------------
module rgb565_gray_decimator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgd_pkg::*;

  localparam int DECIM         = 2;
  localparam int MAX_SIDE      = 4096;
  localparam int RANDOM_PIXELS = 400;
  localparam int STALL_LIMIT   = 1000;

  localparam logic [7:0] R_LUMA [32] = '{
    8'd0,  8'd2,  8'd4,  8'd7,  8'd9,  8'd12, 8'd14, 8'd17,
    8'd19, 8'd22, 8'd24, 8'd27, 8'd29, 8'd31, 8'd34, 8'd36,
    8'd39, 8'd41, 8'd44, 8'd46, 8'd49, 8'd51, 8'd53, 8'd56,
    8'd58, 8'd61, 8'd63, 8'd66, 8'd68, 8'd71, 8'd73, 8'd76
  };
  localparam logic [7:0] G_LUMA [64] = '{
    8'd0,   8'd2,   8'd4,   8'd7,   8'd9,   8'd11,  8'd14,  8'd16,
    8'd18,  8'd21,  8'd23,  8'd25,  8'd28,  8'd30,  8'd32,  8'd35,
    8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd53,
    8'd56,  8'd58,  8'd60,  8'd63,  8'd65,  8'd67,  8'd70,  8'd72,
    8'd74,  8'd77,  8'd79,  8'd81,  8'd84,  8'd86,  8'd88,  8'd91,
    8'd93,  8'd95,  8'd98,  8'd100, 8'd102, 8'd105, 8'd107, 8'd109,
    8'd112, 8'd114, 8'd116, 8'd119, 8'd121, 8'd123, 8'd126, 8'd128,
    8'd130, 8'd133, 8'd135, 8'd137, 8'd140, 8'd142, 8'd144, 8'd147
  };
  localparam logic [7:0] B_LUMA [32] = '{
    8'd0,  8'd0,  8'd1,  8'd2,  8'd3,  8'd4,  8'd5,  8'd6,
    8'd7,  8'd8,  8'd9,  8'd10, 8'd11, 8'd12, 8'd13, 8'd14,
    8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22,
    8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd29
  };

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              row_end;
    logic              frame_last;
  } gray_word_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 pixel_valid;
  logic                 pixel_ready;
  logic [PIXEL_W-1:0]   pixel;
  logic                 gray_valid;
  logic                 gray_ready;
  logic [GRAY_W-1:0]    gray;
  logic                 row_end;
  logic                 frame_last;

  gray_word_t   pending_gray[$];
  logic [12:0]  width_reg;
  logic [12:0]  height_reg;
  logic [11:0]  col_pos;
  logic [11:0]  row_pos;
  bit           gaps_on;
  int           errors;
  int           pixels_sent;
  int           words_seen;
  int           sizes_used;
  int           idle_cycles;

  rgb565_gray_decimator_unit #(
    .DECIMATION(DECIM),
    .MAX_DIM   (MAX_SIDE)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel      (pixel),
    .gray_valid (gray_valid),
    .gray_ready (gray_ready),
    .gray       (gray),
    .row_end    (row_end),
    .frame_last (frame_last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int clamp_side(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [12:0] pick_side();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return 13'($urandom_range(2, 7));
    if (r < 17) return 13'($urandom_range(0, 1));
    if (r == 17) return 13'd4096;
    if (r == 18) return 13'd8191;
    return 13'($urandom_range(8, 8191));
  endfunction

  function automatic void log_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic predict_gray(logic [PIXEL_W-1:0] p);
    int         w, h, out_w, out_h, c, r;
    bit         keep;
    gray_word_t word;
    w     = clamp_side(width_reg);
    h     = clamp_side(height_reg);
    out_w = w / DECIM;
    out_h = h / DECIM;
    c     = int'(col_pos);
    r     = int'(row_pos);
    keep  = out_w > 0 && out_h > 0 && c % DECIM == 0 && r % DECIM == 0 &&
            c < out_w * DECIM && r < out_h * DECIM;
    if (keep) begin
      word.gray       = R_LUMA[p[15:11]] + G_LUMA[p[10:5]] + B_LUMA[p[4:0]];
      word.row_end    = c == (out_w - 1) * DECIM;
      word.frame_last = word.row_end && r == (out_h - 1) * DECIM;
      pending_gray.push_back(word);
    end
    if (c + 1 >= w) begin
      col_pos = '0;
      row_pos = (r + 1 >= h) ? 12'd0 : 12'(r + 1);
    end else begin
      col_pos = 12'(c + 1);
    end
  endtask

  task automatic send_pixel(logic [PIXEL_W-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    do @(posedge clk); while (!pixel_ready);
    predict_gray(p);
    pixels_sent++;
  endtask

  // drop valid, wait out every pending word and the pipeline behind it
  task automatic drain();
    pixel_valid <= 1'b0;
    while (pending_gray.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [12:0] w, logic [12:0] h);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    width_reg  = w;
    height_reg = h;
    sizes_used++;
  endtask

  task automatic test_channel_extremes();
    logic [PIXEL_W-1:0] hues [5];
    hues = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F};
    gaps_on = 1'b0;
    for (int i = 0; i < 5; i++) begin
      send_pixel(hues[i]);
      send_pixel(PIXEL_W'($urandom));
    end
  endtask

  task automatic test_mid_frame_resize();
    gaps_on = 1'b1;
    write_size(13'd2, 13'd2);
    repeat (5) send_pixel(PIXEL_W'($urandom));
  endtask

  task automatic test_degenerate_sizes();
    write_size(13'd0, 13'd0);
    repeat (2) send_pixel(PIXEL_W'($urandom));
    write_size(13'd1, 13'd8191);
    repeat (2) send_pixel(PIXEL_W'($urandom));
    write_size(13'd8191, 13'd3);
    repeat (3) send_pixel(PIXEL_W'($urandom));
    write_size(13'd4096, 13'd1);
    repeat (2) send_pixel(PIXEL_W'($urandom));
  endtask

  task automatic test_random_frames();
    int start;
    int n;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      write_size(pick_side(), pick_side());
      gaps_on = $urandom_range(0, 3) != 0;
      n = $urandom_range(8, 60);
      repeat (n) send_pixel(PIXEL_W'($urandom));
    end
  endtask

  initial begin : ready_driver
    int run;
    int hold;
    gray_ready = 1'b0;
    wait (!rst);
    forever begin
      gray_ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        gray_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : gray_check
    gray_word_t want;
    if (!rst && gray_valid && gray_ready) begin
      words_seen++;
      if (pending_gray.size() == 0) begin
        log_error($sformatf("unexpected word gray=%0d row_end=%0b frame_last=%0b",
                            gray, row_end, frame_last));
      end else begin
        want = pending_gray.pop_front();
        if (gray !== want.gray)
          log_error($sformatf("gray exp %0d got %0d", want.gray, gray));
        if (row_end !== want.row_end)
          log_error($sformatf("row_end exp %0b got %0b", want.row_end, row_end));
        if (frame_last !== want.frame_last)
          log_error($sformatf("frame_last exp %0b got %0b", want.frame_last,
                              frame_last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (gray_valid && gray_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = REG_FRAME_WIDTH;
    cfg_data    = '0;
    pixel_valid = 1'b0;
    pixel       = '0;
    width_reg   = RST_FRAME_WIDTH;
    height_reg  = RST_FRAME_HEIGHT;
    col_pos     = '0;
    row_pos     = '0;
    gaps_on     = 1'b0;
    errors      = 0;
    pixels_sent = 0;
    words_seen  = 0;
    sizes_used  = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_channel_extremes();
    test_mid_frame_resize();
    test_degenerate_sizes();
    test_random_frames();
    drain();
    repeat (8) @(posedge clk);
    if (pending_gray.size() != 0)
      log_error($sformatf("%0d gray words never arrived", pending_gray.size()));
    $display("sent %0d pixels over %0d frame size settings", pixels_sent, sizes_used);
    $display("checked %0d gray words, %0d mismatches", words_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
